/* rtl/core/lmd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd_pkg
// Shared types, constants and the Morse lookup for the light Morse decoder.
// ----------------------------------------------------------------------------
package lmd_pkg;

	localparam int SAMPLE_BITS  = 10;
	localparam int MAX_SYMBOLS  = 7;
	localparam int COUNT_BITS   = 16;
	localparam int REG_BITS     = 16;
	localparam int SYM_CNT_BITS = $clog2(MAX_SYMBOLS + 1);
	localparam int CHAR_BITS    = 7;
	localparam int CMP_BITS     = (COUNT_BITS > REG_BITS) ? COUNT_BITS : REG_BITS;
	localparam int QDEPTH       = 4;
	localparam int QPTR_BITS    = $clog2(QDEPTH);
	localparam int ADDR_BITS    = 4;
	localparam int APB_DATA_BITS = 32;

	localparam logic [SAMPLE_BITS-1:0] ON_LEVEL_RST   = SAMPLE_BITS'(250);
	localparam logic [REG_BITS-1:0]    DOT_LIMIT_RST  = REG_BITS'(200);
	localparam logic [REG_BITS-1:0]    LETTER_GAP_RST = REG_BITS'(2500);
	localparam logic [REG_BITS-1:0]    END_GAP_RST    = REG_BITS'(10000);

	localparam logic [CHAR_BITS-1:0] CHAR_SPACE = CHAR_BITS'(32);

	typedef enum logic [1:0] {
		KIND_DOT  = 2'd0,
		KIND_DASH = 2'd1,
		KIND_CHAR = 2'd2,
		KIND_DONE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_ON_LEVEL   = 2'd0,
		REG_DOT_LIMIT  = 2'd1,
		REG_LETTER_GAP = 2'd2,
		REG_END_GAP    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] on_level;
		logic [REG_BITS-1:0]    dot_limit;
		logic [REG_BITS-1:0]    letter_gap;
		logic [REG_BITS-1:0]    end_gap;
	} cfg_t;

	// results caused by one sample, in emission order sym, chr, done
	typedef struct packed {
		logic                 sym_v;
		logic                 dash;
		logic                 chr_v;
		logic [CHAR_BITS-1:0] chr;
		logic                 done_v;
	} evt_t;

	function automatic logic [SYM_CNT_BITS+MAX_SYMBOLS-1:0] mkey(
		input int len,
		input logic [6:0] pat
	);
		mkey = {SYM_CNT_BITS'(len), MAX_SYMBOLS'(pat)};
	endfunction

	// pattern is in send order, right aligned, dash = 1
	function automatic logic [CHAR_BITS-1:0] morse_lookup(
		input logic [SYM_CNT_BITS-1:0] cnt,
		input logic [MAX_SYMBOLS-1:0]  pat,
		input logic                    ovf
	);
		logic [7:0] c;
		c = {1'b0, CHAR_SPACE};
		unique case ({cnt, pat})
			mkey(2, 7'b01):      c = "A";
			mkey(4, 7'b1000):    c = "B";
			mkey(4, 7'b1010):    c = "C";
			mkey(3, 7'b100):     c = "D";
			mkey(1, 7'b0):       c = "E";
			mkey(4, 7'b0010):    c = "F";
			mkey(3, 7'b110):     c = "G";
			mkey(4, 7'b0000):    c = "H";
			mkey(2, 7'b00):      c = "I";
			mkey(4, 7'b0111):    c = "J";
			mkey(3, 7'b101):     c = "K";
			mkey(4, 7'b0100):    c = "L";
			mkey(2, 7'b11):      c = "M";
			mkey(2, 7'b10):      c = "N";
			mkey(3, 7'b111):     c = "O";
			mkey(4, 7'b0110):    c = "P";
			mkey(4, 7'b1101):    c = "Q";
			mkey(3, 7'b010):     c = "R";
			mkey(3, 7'b000):     c = "S";
			mkey(1, 7'b1):       c = "T";
			mkey(3, 7'b001):     c = "U";
			mkey(4, 7'b0001):    c = "V";
			mkey(3, 7'b011):     c = "W";
			mkey(4, 7'b1001):    c = "X";
			mkey(4, 7'b1011):    c = "Y";
			mkey(4, 7'b1100):    c = "Z";
			mkey(5, 7'b11111):   c = "0";
			mkey(5, 7'b01111):   c = "1";
			mkey(5, 7'b00111):   c = "2";
			mkey(5, 7'b00011):   c = "3";
			mkey(5, 7'b00001):   c = "4";
			mkey(5, 7'b00000):   c = "5";
			mkey(5, 7'b10000):   c = "6";
			mkey(5, 7'b11000):   c = "7";
			mkey(5, 7'b11100):   c = "8";
			mkey(5, 7'b11110):   c = "9";
			mkey(6, 7'b010101):  c = ".";
			mkey(6, 7'b110011):  c = ",";
			mkey(6, 7'b001100):  c = "?";
			mkey(6, 7'b011110):  c = "'";
			mkey(6, 7'b101011):  c = "!";
			mkey(5, 7'b10010):   c = "/";
			mkey(5, 7'b10110):   c = "(";
			mkey(6, 7'b101101):  c = ")";
			mkey(5, 7'b01000):   c = "&";
			mkey(6, 7'b111000):  c = ":";
			mkey(6, 7'b101010):  c = ";";
			mkey(5, 7'b10001):   c = "=";
			mkey(5, 7'b01010):   c = "+";
			mkey(6, 7'b100001):  c = "-";
			mkey(6, 7'b001101):  c = "_";
			mkey(6, 7'b010010):  c = "\"";
			mkey(7, 7'b0001001): c = "$";
			mkey(6, 7'b011010):  c = "@";
			default:             c = {1'b0, CHAR_SPACE};
		endcase
		morse_lookup = ovf ? CHAR_SPACE : c[CHAR_BITS-1:0];
	endfunction

endpackage

/* rtl/core/lmd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd_front
// Sample classifier: run counters, symbol store and character decode.
// ----------------------------------------------------------------------------
module lmd_front import lmd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   accept,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   push,
	output evt_t                   evt
);

	logic [COUNT_BITS-1:0]   on_run_q, gap_run_q, idle_run_q;
	logic [COUNT_BITS-1:0]   on_run_n, gap_run_n, idle_run_n, gap_inc, idle_inc;
	logic [MAX_SYMBOLS-1:0]  pat_q, pat_n;
	logic [SYM_CNT_BITS-1:0] cnt_q, cnt_n;
	logic                    ovf_q, ovf_n;
	logic                    finished_q;
	logic                    light_on, sym_v, dash, chr_v, done_v;

	assign gap_inc  = (&gap_run_q) ? gap_run_q : gap_run_q + COUNT_BITS'(1);
	assign idle_inc = (&idle_run_q) ? idle_run_q : idle_run_q + COUNT_BITS'(1);

	always_comb begin
		light_on   = sample <= cfg.on_level;
		sym_v      = 1'b0;
		dash       = CMP_BITS'(on_run_q) > CMP_BITS'(cfg.dot_limit);
		pat_n      = pat_q;
		cnt_n      = cnt_q;
		ovf_n      = ovf_q;
		on_run_n   = on_run_q;
		gap_run_n  = gap_run_q;
		idle_run_n = idle_run_q;
		if (light_on) begin
			on_run_n   = (&on_run_q) ? on_run_q : on_run_q + COUNT_BITS'(1);
			gap_run_n  = '0;
			idle_run_n = '0;
		end else begin
			if (on_run_q != '0) begin
				sym_v = 1'b1;
				if (cnt_q < SYM_CNT_BITS'(MAX_SYMBOLS)) begin
					// shift in so the store stays in send order
					pat_n = {pat_q[MAX_SYMBOLS-2:0], dash};
					cnt_n = cnt_q + SYM_CNT_BITS'(1);
				end else begin
					ovf_n = 1'b1;
				end
				on_run_n = '0;
			end
			gap_run_n  = gap_inc;
			idle_run_n = idle_inc;
		end
		chr_v   = 1'b0;
		evt.chr = '0;
		if (CMP_BITS'(gap_run_n) >= CMP_BITS'(cfg.letter_gap)) begin
			if (cnt_n != '0 || ovf_n) begin
				chr_v   = 1'b1;
				evt.chr = morse_lookup(cnt_n, pat_n, ovf_n);
				pat_n   = '0;
				cnt_n   = '0;
				ovf_n   = 1'b0;
			end
			gap_run_n = '0;
		end
		done_v     = CMP_BITS'(idle_run_n) >= CMP_BITS'(cfg.end_gap);
		evt.sym_v  = sym_v;
		evt.dash   = dash;
		evt.chr_v  = chr_v;
		evt.done_v = done_v;
	end

	wire step = accept && !finished_q;
	assign push = step && (sym_v || chr_v || done_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_run_q   <= '0;
			gap_run_q  <= '0;
			idle_run_q <= '0;
			pat_q      <= '0;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			finished_q <= 1'b0;
		end else if (step) begin
			on_run_q   <= on_run_n;
			gap_run_q  <= gap_run_n;
			idle_run_q <= idle_run_n;
			pat_q      <= pat_n;
			cnt_q      <= cnt_n;
			ovf_q      <= ovf_n;
			finished_q <= done_v;
		end
	end

endmodule

/* rtl/core/lmd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd_queue
// Short first-word-fall-through queue of per-sample result groups.
// ----------------------------------------------------------------------------
module lmd_queue import lmd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  evt_t wr_data,
	input  logic pop,
	output evt_t rd_data,
	output logic full,
	output logic empty
);

	evt_t                 mem [QDEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;

	assign full    = count_q == (QPTR_BITS + 1)'(QDEPTH);
	assign empty   = count_q == '0;
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_BITS + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_BITS + 1)'(1);
			end
		end
	end

endmodule

/* rtl/core/lmd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmd_back
// Result serializer: sends the results of one group as single beats.
// ----------------------------------------------------------------------------
module lmd_back import lmd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  evt_t                 q_data,
	input  logic                 q_empty,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output kind_t                out_kind,
	output logic [CHAR_BITS-1:0] out_char,
	output logic                 out_last
);

	// pending results: bit 0 symbol, bit 1 character, bit 2 done
	logic [2:0] pend_q, pend_after;
	evt_t       evt_q;
	logic       fire, free;

	assign pend_after = pend_q & (pend_q - 3'd1);
	assign out_valid  = pend_q != 3'd0;
	assign out_last   = pend_after == 3'd0;
	assign fire       = out_valid && out_ready;
	assign free       = !out_valid || (fire && out_last);
	assign q_pop      = free && !q_empty;

	always_comb begin
		out_char = '0;
		if (pend_q[0]) begin
			out_kind = evt_q.dash ? KIND_DASH : KIND_DOT;
		end else if (pend_q[1]) begin
			out_kind = KIND_CHAR;
			out_char = evt_q.chr;
		end else begin
			out_kind = KIND_DONE;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			evt_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'd0;
		end else if (q_pop) begin
			pend_q <= {q_data.done_v, q_data.chr_v, q_data.sym_v};
		end else if (fire) begin
			pend_q <= pend_after;
		end
	end

endmodule

/* rtl/core/light_morse_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_morse_decoder
// Morse decoder for a light sensor stream with an APB register port.
// ----------------------------------------------------------------------------
// one sample accepted per cycle while the 4-group result queue has room
// results of an accepted sample are written into the result queue, then loaded
// into the serializer's pending register once it is free, making the first beat valid
// results leave at one beat per cycle while m_tready is high; a sample can cause up to 3 beats,
// so the output port sets the sustained rate when results are dense
// reset clears counters, symbol store and queue; registers take reset values
module light_morse_decoder import lmd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [15:0]              s_tdata,  // [9:0] light_sample
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [15:0]              m_tdata,  // [1:0] kind, [8:2] char_code
	output logic                     m_tlast,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_BITS-1:0]     paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	cfg_t                 cfg_q;
	evt_t                 evt, q_data;
	logic                 push, q_pop, q_full, q_empty, accept;
	kind_t                out_kind;
	logic [CHAR_BITS-1:0] out_char;
	reg_idx_t             reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_level   <= ON_LEVEL_RST;
			cfg_q.dot_limit  <= DOT_LIMIT_RST;
			cfg_q.letter_gap <= LETTER_GAP_RST;
			cfg_q.end_gap    <= END_GAP_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_ON_LEVEL:   cfg_q.on_level   <= pwdata[SAMPLE_BITS-1:0];
				REG_DOT_LIMIT:  cfg_q.dot_limit  <= pwdata[REG_BITS-1:0];
				REG_LETTER_GAP: cfg_q.letter_gap <= pwdata[REG_BITS-1:0];
				REG_END_GAP:    cfg_q.end_gap    <= pwdata[REG_BITS-1:0];
				default:        cfg_q.end_gap    <= cfg_q.end_gap;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ON_LEVEL:   prdata = APB_DATA_BITS'(cfg_q.on_level);
			REG_DOT_LIMIT:  prdata = APB_DATA_BITS'(cfg_q.dot_limit);
			REG_LETTER_GAP: prdata = APB_DATA_BITS'(cfg_q.letter_gap);
			REG_END_GAP:    prdata = APB_DATA_BITS'(cfg_q.end_gap);
			default:        prdata = '0;
		endcase
	end

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	lmd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.accept (accept),
		.sample (s_tdata[SAMPLE_BITS-1:0]),
		.push   (push),
		.evt    (evt)
	);

	lmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (evt),
		.pop     (q_pop),
		.rd_data (q_data),
		.full    (q_full),
		.empty   (q_empty)
	);

	lmd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_data    (q_data),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (out_kind),
		.out_char  (out_char),
		.out_last  (m_tlast)
	);

	assign m_tdata = {7'd0, out_char, out_kind};

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_morse_decoder testbench
// Streams light samples into the decoder and checks every dot, dash,
// character and end-of-message beat against a cycle-free model of the
// decoder kept in the bench. Registers are set over APB between phases and
// read back. Directed phases cover thresholds, the full symbol store and
// gap extremes; random phases send Morse letters mixed with noise, the first
// two of them under bursty input and a stalling output.
// ----------------------------------------------------------------------------
module testbench;
	import lmd_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 200;
	localparam int MAX_LEVEL    = (1 << SAMPLE_BITS) - 1;

	typedef enum int {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PATTERN
	} rx_mode_t;

	typedef struct packed {
		kind_t                kind;
		logic [CHAR_BITS-1:0] code;
		logic                 last;
	} morse_beat_t;

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [15:0]              s_tdata = '0;  // [9:0] light_sample
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [15:0]              m_tdata;       // [1:0] kind, [8:2] char_code
	logic                     m_tlast;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [ADDR_BITS-1:0]     paddr = '0;
	logic [APB_DATA_BITS-1:0] pwdata = '0;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	light_morse_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// morse table in the order of a standard chart, characters alongside
	string morse_pat [54] = '{
		".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
		"-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
		"..-", "...-", ".--", "-..-", "-.--", "--..",
		"-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
		"---..", "----.",
		".-.-.-", "--..--", "..--..", ".----.", "-.-.--", "-..-.", "-.--.",
		"-.--.-", ".-...", "---...", "-.-.-.", "-...-", ".-.-.", "-....-",
		"..--.-", ".-..-.", "...-..-", ".--.-."
	};
	string morse_chr = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,?'!/()&:;=+-_\"$@";

	// decoder model state
	logic [SAMPLE_BITS-1:0] cfg_on_level   = ON_LEVEL_RST;
	logic [REG_BITS-1:0]    cfg_dot_limit  = DOT_LIMIT_RST;
	logic [REG_BITS-1:0]    cfg_letter_gap = LETTER_GAP_RST;
	logic [REG_BITS-1:0]    cfg_end_gap    = END_GAP_RST;
	logic [COUNT_BITS-1:0]  lit_len  = '0;
	logic [COUNT_BITS-1:0]  gap_len  = '0;
	logic [COUNT_BITS-1:0]  dark_len = '0;
	logic [MAX_SYMBOLS-1:0] sym_pat  = '0;
	logic [2:0]             sym_cnt  = '0;
	logic                   sym_ovf  = 1'b0;
	logic                   msg_done = 1'b0;

	morse_beat_t expected_beats [$];

	int       fail_count    = 0;
	int       cycle_count   = 0;
	int       samples_sent  = 0;
	int       beats_checked = 0;
	int       chars_seen    = 0;
	int       burst_left    = 0;
	bit       sender_gaps   = 1'b1;
	rx_mode_t rx_mode       = RX_RANDOM;
	int       hold_req      = 0;
	int       hold_seen     = 0;
	int       hold_left     = 0;
	int       rx_phase      = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("light_morse_decoder test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// model of the decoder
	// ------------------------------------------------------------------
	function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	function automatic logic [CHAR_BITS-1:0] lookup_letter();
		string code;
		code = "";
		if (sym_ovf)
			return CHAR_SPACE;
		for (int i = 0; i < int'(sym_cnt); i++)
			code = sym_pat[i] ? {code, "-"} : {code, "."};
		foreach (morse_pat[e])
			if (morse_pat[e] == code)
				return CHAR_BITS'(morse_chr[e]);
		return CHAR_SPACE;
	endfunction

	task automatic decode_sample(input logic [SAMPLE_BITS-1:0] level);
		morse_beat_t group [$];
		morse_beat_t b;
		logic        is_dash;
		if (msg_done)
			return;
		if (level <= cfg_on_level) begin
			lit_len  = bump(lit_len);
			gap_len  = '0;
			dark_len = '0;
		end else begin
			if (lit_len != 0) begin
				is_dash = lit_len > cfg_dot_limit;
				b.kind = is_dash ? KIND_DASH : KIND_DOT;
				b.code = '0;
				b.last = 1'b0;
				group.push_back(b);
				// a symbol past the full store is reported but spoils the letter
				if (int'(sym_cnt) < MAX_SYMBOLS) begin
					sym_pat[sym_cnt] = is_dash;
					sym_cnt = sym_cnt + 1'b1;
				end else begin
					sym_ovf = 1'b1;
				end
				lit_len = '0;
			end
			gap_len  = bump(gap_len);
			dark_len = bump(dark_len);
		end
		if (gap_len >= cfg_letter_gap) begin
			if (sym_cnt != 0 || sym_ovf) begin
				b.kind = KIND_CHAR;
				b.code = lookup_letter();
				b.last = 1'b0;
				group.push_back(b);
				sym_pat = '0;
				sym_cnt = '0;
				sym_ovf = 1'b0;
			end
			gap_len = '0;
		end
		if (dark_len >= cfg_end_gap) begin
			b.kind = KIND_DONE;
			b.code = '0;
			b.last = 1'b0;
			group.push_back(b);
			msg_done = 1'b1;
		end
		if (group.size() > 0)
			group[group.size() - 1].last = 1'b1;
		foreach (group[i])
			expected_beats.push_back(group[i]);
	endtask

	// ------------------------------------------------------------------
	// output side
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		rx_phase++;
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_ALWAYS: begin
					m_tready <= 1'b1;
				end
				RX_RANDOM: begin
					m_tready <= ($urandom_range(9, 0) < 6);
				end
				default: begin
					m_tready <= (rx_phase % 7) < 4;
				end
			endcase
		end
	end

	always @(posedge clk) begin
		morse_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			beats_checked++;
			if (expected_beats.size() == 0) begin
				$error("unexpected beat: kind %0d char_code %0h last %0b",
					m_tdata[1:0], m_tdata[8:2], m_tlast);
				fail_count++;
			end else begin
				want = expected_beats.pop_front();
				if (m_tdata[1:0] !== want.kind) begin
					$error("kind mismatch: expected %0d, actual %0d", want.kind, m_tdata[1:0]);
					fail_count++;
				end
				if (m_tdata[8:2] !== want.code) begin
					$error("char_code mismatch: expected %0h, actual %0h",
						want.code, m_tdata[8:2]);
					fail_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last mismatch: expected %0b, actual %0b", want.last, m_tlast);
					fail_count++;
				end
				if (want.kind == KIND_CHAR)
					chars_seen++;
			end
		end
	end

	// ------------------------------------------------------------------
	// input side and register access
	// ------------------------------------------------------------------
	task automatic send_sample(input logic [SAMPLE_BITS-1:0] level);
		int gap;
		if (burst_left == 0) begin
			if (sender_gaps) begin
				gap = $urandom_range(6, 1);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = sender_gaps ? $urandom_range(12, 1) : 1000;
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(16 - SAMPLE_BITS){1'b0}}, level};
		do @(posedge clk); while (!s_tready);
		decode_sample(level);
		samples_sent++;
		burst_left--;
	endtask

	// lets the output drain, then waits out the pipeline for samples with no beat
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (expected_beats.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [REG_BITS-1:0] value);
		logic [APB_DATA_BITS-1:0] keep;
		logic [APB_DATA_BITS-1:0] masked;
		keep   = (idx == REG_ON_LEVEL) ? APB_DATA_BITS'(MAX_LEVEL) : APB_DATA_BITS'(16'hFFFF);
		masked = APB_DATA_BITS'(value) & keep;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_BITS'(idx) << 2;
		// junk above the register width must be dropped
		pwdata  <= ($urandom() & ~keep) | masked;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_ON_LEVEL: begin
				cfg_on_level = masked[SAMPLE_BITS-1:0];
			end
			REG_DOT_LIMIT: begin
				cfg_dot_limit = masked[REG_BITS-1:0];
			end
			REG_LETTER_GAP: begin
				cfg_letter_gap = masked[REG_BITS-1:0];
			end
			default: begin
				cfg_end_gap = masked[REG_BITS-1:0];
			end
		endcase
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== masked) begin
			$error("prdata mismatch on register %0d: expected %0h, actual %0h",
				idx, masked, prdata);
			fail_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [SAMPLE_BITS-1:0] light_on();
		return SAMPLE_BITS'($urandom_range(int'(cfg_on_level), 0));
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] light_off();
		return SAMPLE_BITS'($urandom_range(MAX_LEVEL, int'(cfg_on_level) + 1));
	endfunction

	function automatic logic [8:0] code_bits(input string p);
		logic [8:0] bits;
		bits = '0;
		for (int i = 0; i < p.len(); i++)
			bits[i] = (p[i] == "-");
		return bits;
	endfunction

	// one letter: symbols apart by short gaps, closed by a full letter gap
	task automatic send_letter(input int n, input logic [8:0] pat);
		int run;
		int gap;
		for (int i = 0; i < n; i++) begin
			if (pat[i])
				run = $urandom_range(int'(cfg_dot_limit) + 3, int'(cfg_dot_limit) + 1);
			else
				run = $urandom_range(int'(cfg_dot_limit), 1);
			repeat (run) send_sample(light_on());
			if (i < n - 1)
				gap = $urandom_range((cfg_letter_gap > 4) ? 3 : int'(cfg_letter_gap) - 1, 1);
			else
				gap = int'(cfg_letter_gap);
			repeat (gap) send_sample(light_off());
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_power_on();
		// reset thresholds, with both sides of the on level
		send_sample(SAMPLE_BITS'(0));
		send_sample(ON_LEVEL_RST);
		send_sample(ON_LEVEL_RST + 1'b1);
		send_sample(SAMPLE_BITS'(MAX_LEVEL));
	endtask

	task automatic test_thresholds();
		wait_idle();
		write_reg(REG_END_GAP, 16'hFFFF);
		write_reg(REG_ON_LEVEL, 16'd0);
		send_sample(SAMPLE_BITS'(0));
		send_sample(SAMPLE_BITS'(0));
		send_sample(SAMPLE_BITS'(1));
		wait_idle();
		// every level counts as light on
		write_reg(REG_ON_LEVEL, 16'(MAX_LEVEL));
		send_sample(SAMPLE_BITS'(MAX_LEVEL));
		send_sample(SAMPLE_BITS'(512));
		wait_idle();
		write_reg(REG_ON_LEVEL, 16'd600);
		send_sample(SAMPLE_BITS'(700));
		wait_idle();
		write_reg(REG_DOT_LIMIT, 16'd0);
		send_sample(SAMPLE_BITS'(5));
		send_sample(SAMPLE_BITS'(MAX_LEVEL));
		wait_idle();
		write_reg(REG_DOT_LIMIT, 16'hFFFF);
		repeat (3) send_sample(light_on());
		send_sample(light_off());
	endtask

	task automatic test_letter_gap_extremes();
		wait_idle();
		write_reg(REG_ON_LEVEL, 16'd511);
		write_reg(REG_DOT_LIMIT, 16'd1);
		write_reg(REG_LETTER_GAP, 16'hFFFF);
		repeat (2) begin
			send_sample(light_on());
			send_sample(light_off());
		end
		wait_idle();
		write_reg(REG_LETTER_GAP, 16'd1);
		send_sample(light_off());
	endtask

	task automatic test_full_store();
		wait_idle();
		write_reg(REG_LETTER_GAP, 16'd2);
		send_letter(7, code_bits("...-..-"));
		// one or two symbols too many spoil the letter
		send_letter(8, 9'($urandom()));
		send_letter(9, 9'($urandom()));
	endtask

	task automatic test_zero_letter_gap();
		wait_idle();
		write_reg(REG_LETTER_GAP, 16'hFFFF);
		send_sample(light_on());
		send_sample(light_off());
		wait_idle();
		// a stored symbol decodes even while the light is on
		write_reg(REG_LETTER_GAP, 16'd0);
		send_sample(light_on());
		send_sample(light_on());
		send_sample(light_off());
	endtask

	task automatic test_backpressure();
		wait_idle();
		write_reg(REG_LETTER_GAP, 16'd2);
		write_reg(REG_DOT_LIMIT, 16'd1);
		sender_gaps = 1'b0;
		hold_req++;
		repeat (10) begin
			send_sample(light_on());
			send_sample(light_off());
			send_sample(light_off());
		end
		sender_gaps = 1'b1;
	endtask

	task automatic test_random_traffic();
		int    start;
		int    pick;
		int    e;
		int    n;
		string p;
		for (int ph = 0; ph < 3; ph++) begin
			wait_idle();
			rx_mode     = (ph == 0) ? RX_RANDOM : (ph == 1) ? RX_PATTERN : RX_ALWAYS;
			sender_gaps = (ph != 2);
			write_reg(REG_ON_LEVEL, 16'($urandom_range(MAX_LEVEL - 1, 1)));
			write_reg(REG_DOT_LIMIT, 16'($urandom_range(3, 1)));
			write_reg(REG_LETTER_GAP, 16'($urandom_range(5, 2)));
			write_reg(REG_END_GAP, 16'($urandom_range(65535, 2000)));
			start = samples_sent;
			while (samples_sent - start < 25) begin
				pick = $urandom_range(9, 0);
				if (pick < 6) begin
					e = $urandom_range(53, 0);
					p = morse_pat[e];
					send_letter(p.len(), code_bits(p));
				end else if (pick < 8) begin
					send_letter($urandom_range(7, 1), 9'($urandom()));
				end else if (pick == 8) begin
					send_letter($urandom_range(9, 8), 9'($urandom()));
				end else begin
					n = $urandom_range(8, 1);
					repeat (n) send_sample(SAMPLE_BITS'($urandom_range(MAX_LEVEL, 0)));
				end
			end
		end
		rx_mode     = RX_RANDOM;
		sender_gaps = 1'b1;
	endtask

	task automatic test_message_end();
		wait_idle();
		send_sample(light_on());
		wait_idle();
		write_reg(REG_LETTER_GAP, 16'd1);
		write_reg(REG_END_GAP, 16'd1);
		// dot, letter and end of message from the same sample
		send_sample(light_off());
		// everything after the end is dropped
		repeat (6) send_sample(SAMPLE_BITS'($urandom_range(MAX_LEVEL, 0)));
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_power_on();
		test_thresholds();
		test_letter_gap_extremes();
		test_full_store();
		test_zero_letter_gap();
		test_backpressure();
		test_random_traffic();
		test_message_end();
		wait_idle();
		if (expected_beats.size() != 0) begin
			$error("%0d expected beats never arrived", expected_beats.size());
			fail_count++;
		end
		$display("sent %0d light samples, checked %0d output beats, %0d decoded characters",
			samples_sent, beats_checked, chars_seen);
		$display("covered thresholds, store overflow, gap extremes, message end, stalls");
		if (fail_count == 0)
			$display("light_morse_decoder test passed");
		else
			$display("light_morse_decoder test failed");
		$finish;
	end

endmodule
